[hw/rtl/yiqhr_pkg.sv]
package yiqhr_pkg;

  // Fraction bits of the color matrix coefficients
  localparam int unsigned COEF_FRAC_BITS = 14;
  // Fraction bits of the angle registers (fixed Q2.14)
  localparam int unsigned ANGLE_FRAC_BITS = 14;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ANGLE_W = 16;

  // Coefficients are below 2.0, kept signed with a zero top bit
  localparam int unsigned COEF_W  = COEF_FRAC_BITS + 2;
  // Luma in pixel units with COEF_FRAC_BITS fraction bits
  localparam int unsigned Y_W     = PIX_W + COEF_FRAC_BITS + 1;
  // Chroma I/Q, signed
  localparam int unsigned IQ_W    = PIX_W + COEF_FRAC_BITS + 2;
  // Angle times chroma
  localparam int unsigned PROD_W  = ANGLE_W + IQ_W;
  localparam int unsigned ACC_W   = PROD_W + 1;
  // Rotated chroma, angle magnitude up to 2.0 adds two bits
  localparam int unsigned ROT_W   = IQ_W + 2;
  // Inverse matrix products and three-term sum
  localparam int unsigned OPROD_W = ROT_W + COEF_W;
  localparam int unsigned OUT_W   = OPROD_W + 2;

  localparam longint CoefOne = longint'(1) << COEF_FRAC_BITS;

  // round(k * 2^F), half up, k given in thousandths
  localparam logic signed [COEF_W-1:0] K_YR = COEF_W'((299  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_YG = COEF_W'((587  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_YB = COEF_W'((114  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_IR = COEF_W'((596  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_IG = COEF_W'((274  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_IB = COEF_W'((321  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_QR = COEF_W'((211  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_QG = COEF_W'((523  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_QB = COEF_W'((311  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_RI = COEF_W'((956  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_RQ = COEF_W'((621  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_GI = COEF_W'((272  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_GQ = COEF_W'((647  * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_BI = COEF_W'((1107 * CoefOne + 500) / 1000);
  localparam logic signed [COEF_W-1:0] K_BQ = COEF_W'((1705 * CoefOne + 500) / 1000);

  // Configuration register indexes
  localparam logic CfgCosAngle = 1'b0;
  localparam logic CfgSinAngle = 1'b1;

  localparam logic signed [ANGLE_W-1:0] AngleOne = ANGLE_W'(1 << ANGLE_FRAC_BITS);

  // Pixel in YIQ, between the forward matrix and the rotator
  typedef struct packed {
    logic                   valid;
    logic [Y_W-1:0]         y;
    logic signed [IQ_W-1:0] i;
    logic signed [IQ_W-1:0] q;
  } yiq_t;

  // Rotated pixel, between the rotator and the inverse matrix
  typedef struct packed {
    logic                    valid;
    logic [Y_W-1:0]          y;
    logic signed [ROT_W-1:0] ir;
    logic signed [ROT_W-1:0] qr;
  } rot_t;

endpackage

[hw/rtl/yiqhr_in_if.sv]
interface yiqhr_in_if import yiqhr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

[hw/rtl/yiqhr_out_if.sv]
interface yiqhr_out_if import yiqhr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

[hw/rtl/yiqhr_to_yiq.sv]
module yiqhr_to_yiq import yiqhr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  output yiq_t             yiq_o,
  input  logic             ready_i
);

  logic                   valid_q;
  logic                   en;
  logic [Y_W-1:0]         y_d, y_q;
  logic signed [IQ_W-1:0] i_d, i_q;
  logic signed [IQ_W-1:0] q_d, q_q;
  logic signed [IQ_W-1:0] r_s, g_s, b_s;

  // stage advances when empty or when its result moves on
  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  assign r_s = $signed(IQ_W'(red_i));
  assign g_s = $signed(IQ_W'(green_i));
  assign b_s = $signed(IQ_W'(blue_i));

  // forward matrix, constant coefficients
  always_comb begin
    y_d = Y_W'(K_YR) * Y_W'(red_i) + Y_W'(K_YG) * Y_W'(green_i)
        + Y_W'(K_YB) * Y_W'(blue_i);
    i_d = IQ_W'(K_IR) * r_s - IQ_W'(K_IG) * g_s - IQ_W'(K_IB) * b_s;
    q_d = IQ_W'(K_QR) * r_s - IQ_W'(K_QG) * g_s + IQ_W'(K_QB) * b_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      y_q <= y_d;
      i_q <= i_d;
      q_q <= q_d;
    end
  end

  assign yiq_o = '{valid: valid_q, y: y_q, i: i_q, q: q_q};

endmodule

[hw/rtl/yiqhr_rotate.sv]
module yiqhr_rotate import yiqhr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [ANGLE_W-1:0] cos_i,
  input  logic signed [ANGLE_W-1:0] sin_i,
  input  yiq_t                      yiq_i,
  output logic                      ready_o,
  output rot_t                      rot_o,
  input  logic                      ready_i
);

  logic                     va_q, vb_q;
  logic                     en_a, en_b;
  logic [Y_W-1:0]           ya_q, yb_q;
  logic signed [PROD_W-1:0] ci_q, sq_q, si_q, cq_q;
  logic signed [ACC_W-1:0]  iacc, qacc;
  logic signed [ROT_W-1:0]  ir_d, ir_q, qr_d, qr_q;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  // stage A: four angle products
  always_ff @(posedge clk_i) begin
    if (en_a && yiq_i.valid) begin
      ya_q <= yiq_i.y;
      ci_q <= PROD_W'(cos_i) * PROD_W'(yiq_i.i);
      sq_q <= PROD_W'(sin_i) * PROD_W'(yiq_i.q);
      si_q <= PROD_W'(sin_i) * PROD_W'(yiq_i.i);
      cq_q <= PROD_W'(cos_i) * PROD_W'(yiq_i.q);
    end
  end

  // stage B: I' = cI - sQ, Q' = sI + cQ, floor back to chroma scale
  always_comb begin
    iacc = ACC_W'(ci_q) - ACC_W'(sq_q);
    qacc = ACC_W'(si_q) + ACC_W'(cq_q);
    ir_d = ROT_W'(iacc >>> ANGLE_FRAC_BITS);
    qr_d = ROT_W'(qacc >>> ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      yb_q <= ya_q;
      ir_q <= ir_d;
      qr_q <= qr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= yiq_i.valid;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
    end
  end

  assign rot_o = '{valid: vb_q, y: yb_q, ir: ir_q, qr: qr_q};

endmodule

[hw/rtl/yiqhr_to_rgb.sv]
module yiqhr_to_rgb import yiqhr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rot_t             rot_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [PIX_W-1:0] red_o,
  output logic [PIX_W-1:0] green_o,
  output logic [PIX_W-1:0] blue_o,
  input  logic             ready_i
);

  logic                      va_q, vb_q;
  logic                      en_a, en_b;
  logic signed [OUT_W-1:0]   yw_q;
  logic signed [OPROD_W-1:0] ri_q, rq_q, gi_q, gq_q, bi_q, bq_q;
  logic signed [OUT_W-1:0]   rsum, gsum, bsum;
  logic [PIX_W-1:0]          red_d, green_d, blue_d;
  logic [PIX_W-1:0]          red_q, green_q, blue_q;

  // floor by 2F, then clamp to 0..255
  function automatic logic [PIX_W-1:0] to_pixel(logic signed [OUT_W-1:0] v);
    logic signed [OUT_W-1:0] p;
    p = v >>> (2 * COEF_FRAC_BITS);
    if (p[OUT_W-1]) begin
      return '0;
    end else if (|p[OUT_W-2:PIX_W]) begin
      return '1;
    end else begin
      return p[PIX_W-1:0];
    end
  endfunction

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  // stage A: inverse matrix products, luma scaled to 2F fraction bits
  always_ff @(posedge clk_i) begin
    if (en_a && rot_i.valid) begin
      yw_q <= $signed(OUT_W'(rot_i.y) << COEF_FRAC_BITS);
      ri_q <= OPROD_W'(K_RI) * OPROD_W'(rot_i.ir);
      rq_q <= OPROD_W'(K_RQ) * OPROD_W'(rot_i.qr);
      gi_q <= OPROD_W'(K_GI) * OPROD_W'(rot_i.ir);
      gq_q <= OPROD_W'(K_GQ) * OPROD_W'(rot_i.qr);
      bi_q <= OPROD_W'(K_BI) * OPROD_W'(rot_i.ir);
      bq_q <= OPROD_W'(K_BQ) * OPROD_W'(rot_i.qr);
    end
  end

  // stage B: sums and clamp
  always_comb begin
    rsum    = yw_q + OUT_W'(ri_q) + OUT_W'(rq_q);
    gsum    = yw_q - OUT_W'(gi_q) - OUT_W'(gq_q);
    bsum    = yw_q - OUT_W'(bi_q) + OUT_W'(bq_q);
    red_d   = to_pixel(rsum);
    green_d = to_pixel(gsum);
    blue_d  = to_pixel(bsum);
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= rot_i.valid;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
    end
  end

  assign valid_o = vb_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

[hw/rtl/yiq_hue_rotate_pixel_core.sv]
// YIQ hue rotation, one RGB pixel per transfer.
// A pixel passes the stage registers of u_to_yiq, u_rotate (A, B) and u_to_rgb
// (A, B) in that order before output valid rises.
// Throughput: one pixel per clock while the output accepts; five register
// stages, each held only while its successor is full and stalled.
// Reset clears all stage valid bits and sets cos_angle to 1.0, sin_angle to 0.
module yiq_hue_rotate_pixel_core import yiqhr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [ANGLE_W-1:0]  cfg_wdata_i,
  yiqhr_in_if.sink            pix_i,
  yiqhr_out_if.source         pix_o
);

  logic signed [ANGLE_W-1:0] cos_q, sin_q;
  yiq_t                      yiq;
  rot_t                      rot;
  logic                      rot_ready;
  logic                      rgb_ready;

  // angle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= AngleOne;
      sin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCosAngle: cos_q <= $signed(cfg_wdata_i);
        CfgSinAngle: sin_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  yiqhr_to_yiq u_to_yiq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .red_i   (pix_i.red_in),
    .green_i (pix_i.green_in),
    .blue_i  (pix_i.blue_in),
    .yiq_o   (yiq),
    .ready_i (rot_ready)
  );

  yiqhr_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cos_i   (cos_q),
    .sin_i   (sin_q),
    .yiq_i   (yiq),
    .ready_o (rot_ready),
    .rot_o   (rot),
    .ready_i (rgb_ready)
  );

  yiqhr_to_rgb u_to_rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rot_i   (rot),
    .ready_o (rgb_ready),
    .valid_o (pix_o.valid),
    .red_o   (pix_o.red_out),
    .green_o (pix_o.green_out),
    .blue_o  (pix_o.blue_out),
    .ready_i (pix_o.ready)
  );

  // an accepting sink frees the whole pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.ready |-> pix_i.ready)
    else $error("input stalled while output accepts");

  // input stalls only with the pipe backed up to the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (pix_o.valid && !pix_o.ready && yiq.valid && rot.valid))
    else $error("input stalled with a bubble in the pipe");

  // a stalled rotator result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot.valid && !rgb_ready) |=> (rot.valid && $stable(rot)))
    else $error("rotated pixel changed under stall");

endmodule

[tb/sv/tb_yiq_hue_rotate_pixel_core.sv]
`timescale 1ns / 1ps

module tb_yiq_hue_rotate_pixel_core;
  import yiqhr_pkg::*;

  localparam int PIPE_LATENCY = 5;
  localparam int NUM_ANGLES   = 11;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  // Matrix coefficient in Q.F, rounded half up from thousandths
  function automatic longint milli_q(input int milli);
    return ((longint'(milli) << COEF_FRAC_BITS) + 500) / 1000;
  endfunction

  localparam longint CY_R = milli_q(299);
  localparam longint CY_G = milli_q(587);
  localparam longint CY_B = milli_q(114);
  localparam longint CI_R = milli_q(596);
  localparam longint CI_G = milli_q(274);
  localparam longint CI_B = milli_q(321);
  localparam longint CQ_R = milli_q(211);
  localparam longint CQ_G = milli_q(523);
  localparam longint CQ_B = milli_q(311);
  localparam longint CR_I = milli_q(956);
  localparam longint CR_Q = milli_q(621);
  localparam longint CG_I = milli_q(272);
  localparam longint CG_Q = milli_q(647);
  localparam longint CB_I = milli_q(1107);
  localparam longint CB_Q = milli_q(1705);

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [ANGLE_W-1:0] cfg_wdata;

  yiqhr_in_if  pix_in ();
  yiqhr_out_if pix_out ();

  yiq_hue_rotate_pixel_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  always #5 clk = ~clk;

  // Angle as the block holds it
  longint angle_cos;
  longint angle_sin;

  pixel_t pixels_to_send [$];
  pixel_t rotated_expect [$];

  logic idle_en;
  logic sink_hold;
  int   mismatch_count;
  int   pixels_checked;
  int   src_gap_left;
  int   sink_stall_left;
  int   cycle_count;

  // Floor to integer pixel and saturate
  function automatic logic [PIX_W-1:0] to_channel(input longint v);
    longint p;
    p = v >>> (2 * COEF_FRAC_BITS);
    if (p < 0) return '0;
    if (p > 255) return 8'd255;
    return p[PIX_W-1:0];
  endfunction

  // RGB -> YIQ, rotate chroma, YIQ -> RGB
  function automatic pixel_t rotate_hue(input pixel_t px);
    longint r, g, b, y, i, q, ir, qr, yw;
    pixel_t res;
    r = longint'(px.red);
    g = longint'(px.green);
    b = longint'(px.blue);
    y = CY_R * r + CY_G * g + CY_B * b;
    i = CI_R * r - CI_G * g - CI_B * b;
    q = CQ_R * r - CQ_G * g + CQ_B * b;
    ir = (angle_cos * i - angle_sin * q) >>> ANGLE_FRAC_BITS;
    qr = (angle_sin * i + angle_cos * q) >>> ANGLE_FRAC_BITS;
    yw = y << COEF_FRAC_BITS;
    res.red   = to_channel(yw + CR_I * ir + CR_Q * qr);
    res.green = to_channel(yw - CG_I * ir - CG_Q * qr);
    res.blue  = to_channel(yw - CB_I * ir + CB_Q * qr);
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Source side: offer queued pixels, predict on each transfer
  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    if (rst_n) begin
      if (pix_in.valid && pix_in.ready)
        rotated_expect.push_back(rotate_hue({pix_in.red_in, pix_in.green_in, pix_in.blue_in}));
      if (!pix_in.valid || pix_in.ready) begin
        if (src_gap_left != 0) begin
          pix_in.valid <= 1'b0;
          src_gap_left = src_gap_left - 1;
        end else if (pixels_to_send.size() != 0) begin
          if (idle_en && $urandom_range(0, 7) == 0) begin
            pix_in.valid <= 1'b0;
            src_gap_left = $urandom_range(0, 6);
          end else begin
            nxt = pixels_to_send.pop_front();
            pix_in.valid    <= 1'b1;
            pix_in.red_in   <= nxt.red;
            pix_in.green_in <= nxt.green;
            pix_in.blue_in  <= nxt.blue;
          end
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each transfer, stall in bursts
  always @(posedge clk) begin : pixel_monitor
    pixel_t want;
    if (rst_n) begin
      if (pix_out.valid && pix_out.ready) begin
        if (rotated_expect.size() == 0) begin
          report_error($sformatf("output %0d/%0d/%0d with nothing pending",
                                 pix_out.red_out, pix_out.green_out, pix_out.blue_out));
        end else begin
          want = rotated_expect.pop_front();
          if (pix_out.red_out !== want.red)
            report_error($sformatf("pixel %0d red got %0d, want %0d",
                                   pixels_checked, pix_out.red_out, want.red));
          if (pix_out.green_out !== want.green)
            report_error($sformatf("pixel %0d green got %0d, want %0d",
                                   pixels_checked, pix_out.green_out, want.green));
          if (pix_out.blue_out !== want.blue)
            report_error($sformatf("pixel %0d blue got %0d, want %0d",
                                   pixels_checked, pix_out.blue_out, want.blue));
          pixels_checked++;
        end
      end
      if (sink_hold) begin
        pix_out.ready <= 1'b0;
      end else if (sink_stall_left != 0) begin
        pix_out.ready <= 1'b0;
        sink_stall_left = sink_stall_left - 1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        pix_out.ready <= 1'b0;
        sink_stall_left = $urandom_range(0, 6);
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [ANGLE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgCosAngle) angle_cos = longint'($signed(val));
    else angle_sin = longint'($signed(val));
  endtask

  // Hold until every pixel has gone through and the pipe is empty
  task automatic wait_drained();
    while (pixels_to_send.size() != 0 || rotated_expect.size() != 0 || pix_in.valid)
      @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // The eight corners of the RGB cube
  task automatic queue_corners();
    pixel_t px;
    for (int k = 0; k < 8; k++) begin
      px.red   = k[0] ? 8'd255 : 8'd0;
      px.green = k[1] ? 8'd255 : 8'd0;
      px.blue  = k[2] ? 8'd255 : 8'd0;
      pixels_to_send.push_back(px);
    end
  endtask

  function automatic logic [PIX_W-1:0] random_channel(input bit edgy);
    if (edgy) begin
      case ($urandom_range(0, 2))
        0: return 8'd0;
        1: return 8'd255;
        default: return PIX_W'($urandom);
      endcase
    end
    return PIX_W'($urandom);
  endfunction

  task automatic queue_random(input int count);
    pixel_t px;
    bit edgy;
    for (int n = 0; n < count; n++) begin
      edgy     = ($urandom_range(0, 3) == 0);
      px.red   = random_channel(edgy);
      px.green = random_channel(edgy);
      px.blue  = random_channel(edgy);
      pixels_to_send.push_back(px);
    end
  endtask

  // Cosine and sine for each test phase
  function automatic logic [2*ANGLE_W-1:0] angle_pair(input int phase);
    case (phase)
      0:       return {16'sd0, AngleOne};
      1:       return {-AngleOne, 16'sd0};
      2:       return {16'sd0, -AngleOne};
      3:       return {16'sd11585, 16'sd11585};
      4:       return {16'h7FFF, 16'h7FFF};
      5:       return {16'h8000, 16'h8000};
      6:       return {16'h7FFF, 16'h8000};
      10:      return {AngleOne, 16'sd0};
      default: return {ANGLE_W'($urandom), ANGLE_W'($urandom)};
    endcase
  endfunction

  initial begin : stimulus
    logic [2*ANGLE_W-1:0] pair;
    pixel_t px;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgCosAngle;
    cfg_wdata       = '0;
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_out.ready   = 1'b0;
    idle_en         = 1'b1;
    sink_hold       = 1'b0;
    mismatch_count  = 0;
    pixels_checked  = 0;
    src_gap_left    = 0;
    sink_stall_left = 0;
    cycle_count     = 0;
    angle_cos       = longint'(AngleOne);
    angle_sin       = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset angle: cube corners, mid gray, a dark pixel and random pixels
    queue_corners();
    px = '{red: 8'd128, green: 8'd128, blue: 8'd128};
    pixels_to_send.push_back(px);
    px = '{red: 8'd1, green: 8'd2, blue: 8'd3};
    pixels_to_send.push_back(px);
    queue_random(60);
    wait_drained();

    for (int phase = 0; phase < NUM_ANGLES; phase++) begin
      pair = angle_pair(phase);
      write_reg(CfgCosAngle, pair[2*ANGLE_W-1:ANGLE_W]);
      write_reg(CfgSinAngle, pair[ANGLE_W-1:0]);
      idle_en <= (phase != 3) && (phase != NUM_ANGLES - 1);
      @(negedge clk);
      // Near full-scale angle values drive the channels hard into saturation
      if (phase == 4) queue_corners();
      if (phase == 1) sink_hold <= 1'b1;
      queue_random(phase == NUM_ANGLES - 1 ? 200 : 80);
      // Sink blocked for a while so the pipe backs up into the source
      if (phase == 1) begin
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold <= 1'b0;
      end
      wait_drained();
    end

    $display("Checked %0d pixels over %0d angle settings (reset, quarter turns, 45 deg,",
             pixels_checked, NUM_ANGLES + 1);
    $display("  full-scale and random Q2.14 patterns) with source gaps and sink stalls");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
